@@ rtl/edd_pkg.sv @@
// Shared types, constants and arithmetic helpers for the error-diffusion dither core.
// No dependencies; used by edd_chan, edd_line_mem and error_diffusion_dither_core.
package edd_pkg;

   localparam int PIX_BITS       = 8;
   localparam int ERR_BITS       = 9;
   localparam int LEVEL_BITS_W   = 4;
   localparam int IMG_WIDTH_BITS = 11;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_ADDR_BITS  = 1;
   localparam int NUM_CHAN       = 3;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_LEVEL_BITS  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IMAGE_WIDTH = 1'b1;

   localparam logic [LEVEL_BITS_W-1:0]   LEVEL_BITS_RESET  = 4'd8;
   localparam logic [IMG_WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 11'd1024;
   localparam logic [LEVEL_BITS_W-1:0]   LEVEL_BITS_MIN    = 4'd1;
   localparam logic [LEVEL_BITS_W-1:0]   LEVEL_BITS_MAX    = 4'd8;

   localparam logic [3:0] WEIGHT_ABOVE_LEFT  = 4'd1;
   localparam logic [3:0] WEIGHT_ABOVE       = 4'd5;
   localparam logic [3:0] WEIGHT_ABOVE_RIGHT = 4'd3;
   localparam logic [3:0] WEIGHT_LEFT        = 4'd7;

   typedef logic [PIX_BITS-1:0]        pix_type;
   typedef logic signed [ERR_BITS-1:0] err_type;
   typedef err_type [NUM_CHAN-1:0]     err3_type;

   typedef struct packed {
      logic use_above_left;
      logic use_above;
      logic use_above_right;
      logic use_left;
   } edge_type;

   function automatic pix_type step_lut(logic [LEVEL_BITS_W-1:0] bits);
      pix_type step;
      unique case (bits)
         4'd1:    step = 8'd255;
         4'd2:    step = 8'd85;
         4'd3:    step = 8'd36;
         4'd4:    step = 8'd17;
         4'd5:    step = 8'd8;
         4'd6:    step = 8'd4;
         4'd7:    step = 8'd2;
         default: step = 8'd1;
      endcase
      return step;
   endfunction

   function automatic pix_type add_clamped(pix_type v, err_type e, logic [3:0] k);
      logic signed [12:0] prod;
      logic signed [8:0]  term;
      logic signed [9:0]  sum;
      prod = 13'(e) * 13'($signed({1'b0, k}));
      term = 9'(prod >>> 4);
      sum  = $signed({2'b00, v}) + 10'(term);
      priority if (sum < 10'sd0) begin
         return 8'd0;
      end else if (sum > 10'sd255) begin
         return 8'd255;
      end else begin
         return sum[7:0];
      end
   endfunction

endpackage

@@ rtl/error_diffusion_dither_core.sv @@
// Floyd-Steinberg error-diffusion dither core for an RGBA raster pixel stream.
// Depends on edd_pkg, edd_chan and edd_line_mem.
//
// Accepts one pixel per clock and returns one dithered pixel per clock, in order, while
// rsp_tready stays high. The line store read (above and above-right errors, two read ports)
// registers when the request is accepted, and the compute stage then applies the four
// diffused errors, requantizes and registers the result. Throughput is set by the
// left-error loop, which closes through left_ff, and by the line store's single
// write port taking one row entry per pixel. A waiting response holds the compute stage, so
// one more request is taken and then req_tready stays low until rsp_tready returns;
// rsp_tready reaches req_tready combinationally. The line store holds MAX_WIDTH entries and
// is not cleared after reset; entries are defined once the first row of a frame is written.
module error_diffusion_dither_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // red_in, green_in, blue_in, alpha_in
   input  logic [0:0]                          req_tuser,   // frame_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   input  logic                                csr_we,
   input  logic [edd_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [edd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import edd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > IMG_WIDTH_BITS) ? CW + 1 : IMG_WIDTH_BITS;

   logic [LEVEL_BITS_W-1:0]   level_bits_ff;
   logic [IMG_WIDTH_BITS-1:0] image_width_ff;

   logic [CW-1:0]             col_ff;
   logic [CW-1:0]             col_in;
   logic                      first_ff;
   logic                      first_in;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic [3:0][7:0]           s1_pix_ff;
   edge_type                  s1_edges_ff;
   logic [CW-1:0]             s1_x_ff;
   logic                      s1_fwd_a_ff;
   logic                      s1_fwd_ar_ff;

   err3_type                  left_ff;
   err3_type                  above_left_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [31:0]               rsp_data_ff;

   logic [LEVEL_BITS_W-1:0]   bits_eff;
   logic [2:0]                shift;
   pix_type                   step;
   logic [WW-1:0]             width_eff;
   logic [WW-1:0]             width_ext;

   logic [CW-1:0]             col_start;
   logic                      first_start;
   logic                      wrap;
   logic [CW-1:0]             x;
   logic                      first;
   logic [WW-1:0]             x_next;
   logic                      has_right;
   logic [CW-1:0]             ar_addr;
   edge_type                  edges;
   logic                      accept;
   logic                      s1_fire;

   err3_type                  rd_a;
   err3_type                  rd_ar;
   err3_type                  above;
   err3_type                  above_right;
   err3_type                  cur;
   pix_type [NUM_CHAN-1:0]    quant;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         level_bits_ff  <= LEVEL_BITS_RESET;
         image_width_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_LEVEL_BITS) begin
            level_bits_ff <= csr_wdata[LEVEL_BITS_W-1:0];
         end
         if (csr_addr == CSR_IMAGE_WIDTH) begin
            image_width_ff <= csr_wdata[IMG_WIDTH_BITS-1:0];
         end
      end
   end

   always_comb begin
      priority if (level_bits_ff < LEVEL_BITS_MIN) begin
         bits_eff = LEVEL_BITS_MIN;
      end else if (level_bits_ff > LEVEL_BITS_MAX) begin
         bits_eff = LEVEL_BITS_MAX;
      end else begin
         bits_eff = level_bits_ff;
      end
      shift     = 3'(LEVEL_BITS_MAX - bits_eff);
      step      = step_lut(bits_eff);
      width_ext = WW'(image_width_ff);
      priority if (width_ext == '0) begin
         width_eff = WW'(1);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
   end

   // stage 0: column tracking and line-store read
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_start   = req_tuser[0] ? '0 : col_ff;
      first_start = req_tuser[0] ? 1'b1 : first_ff;
      wrap        = WW'(col_start) >= width_eff;
      x           = wrap ? '0 : col_start;
      first       = wrap ? 1'b0 : first_start;
      x_next      = WW'(x) + WW'(1);
      has_right   = x_next < width_eff;
      ar_addr     = x_next[CW-1:0];
      col_in      = has_right ? x_next[CW-1:0] : '0;
      first_in    = has_right ? first : 1'b0;
      edges.use_above_left  = !first && (x != '0);
      edges.use_above       = !first;
      edges.use_above_right = !first && has_right;
      edges.use_left        = x != '0;
   end

   assign s1_valid_in  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         first_ff      <= 1'b1;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         left_ff       <= '0;
         above_left_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            col_ff   <= col_in;
            first_ff <= first_in;
         end
         if (s1_fire) begin
            left_ff       <= cur;
            above_left_ff <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= req_tdata;
         s1_edges_ff  <= edges;
         s1_x_ff      <= x;
         s1_fwd_a_ff  <= s1_fire && (s1_x_ff == x);
         s1_fwd_ar_ff <= s1_fire && (s1_x_ff == ar_addr);
      end
      if (s1_fire) begin
         rsp_data_ff <= {s1_pix_ff[3], quant[2], quant[1], quant[0]};
      end
   end

   edd_line_mem #(
      .DEPTH(MAX_WIDTH)
   ) u_line_mem (
      .clock     (clock),
      .wr_en     (s1_fire),
      .wr_addr   (s1_x_ff),
      .wr_data   (cur),
      .rd_en     (accept),
      .rd_addr_a (x),
      .rd_addr_b (ar_addr),
      .rd_data_a (rd_a),
      .rd_data_b (rd_ar)
   );

   // stage 1: forward the entry written in the same cycle as its read
   assign above       = s1_fwd_a_ff ? left_ff : rd_a;
   assign above_right = s1_fwd_ar_ff ? left_ff : rd_ar;

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      edd_chan u_chan (
         .pix             (s1_pix_ff[c]),
         .shift           (shift),
         .step            (step),
         .edges           (s1_edges_ff),
         .err_above_left  (above_left_ff[c]),
         .err_above       (above[c]),
         .err_above_right (above_right[c]),
         .err_left        (left_ff[c]),
         .quant           (quant[c]),
         .err             (cur[c])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/edd_chan.sv @@
// One color channel of the dither datapath: diffused-error accumulation and requantization.
// Depends on edd_pkg.
module edd_chan (
   input  edd_pkg::pix_type  pix,
   input  logic [2:0]        shift,
   input  edd_pkg::pix_type  step,
   input  edd_pkg::edge_type edges,
   input  edd_pkg::err_type  err_above_left,
   input  edd_pkg::err_type  err_above,
   input  edd_pkg::err_type  err_above_right,
   input  edd_pkg::err_type  err_left,
   output edd_pkg::pix_type  quant,
   output edd_pkg::err_type  err
);
   import edd_pkg::*;

   pix_type     v1;
   pix_type     v2;
   pix_type     v3;
   pix_type     v4;
   logic [15:0] prod;

   always_comb begin
      v1 = edges.use_above_left ? add_clamped(pix, err_above_left, WEIGHT_ABOVE_LEFT) : pix;
      v2 = edges.use_above ? add_clamped(v1, err_above, WEIGHT_ABOVE) : v1;
      v3 = edges.use_above_right ? add_clamped(v2, err_above_right, WEIGHT_ABOVE_RIGHT) : v2;
      v4 = edges.use_left ? add_clamped(v3, err_left, WEIGHT_LEFT) : v3;
      prod  = 16'(v4 >> shift) * 16'(step);
      quant = prod[7:0];
      err   = $signed({1'b0, v4}) - $signed({1'b0, quant});
   end

endmodule

@@ rtl/edd_line_mem.sv @@
// Line store of the previous row's errors: one write port, two registered read ports.
// Depends on edd_pkg.
module edd_line_mem #(
   parameter  int DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  edd_pkg::err3_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output edd_pkg::err3_type rd_data_a,
   output edd_pkg::err3_type rd_data_b
);
   import edd_pkg::*;

   err3_type ram [DEPTH];
   err3_type rd_data_a_ff;
   err3_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= ram[rd_addr_a];
         rd_data_b_ff <= ram[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
